>>> sv/srs_pkg.sv
// Shared constants for the send/receive schedule keeper.
// Field widths, register indexes, item codes and result field offsets.
// No dependencies.
package srs_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int IV_BITS       = 32;
  localparam int LAT_BITS      = 32;
  localparam int MB_BITS       = 8;
  localparam int FT_BITS       = 48;
  localparam int BUF_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 120;

  localparam logic [CFG_IDX_BITS-1:0] REG_SEND_IV = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECV_IV = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LATENCY = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_BUF = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIDE    = 3'd4;

  localparam logic FUNC_INIT   = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;
  localparam logic SIDE_OUTPUT = 1'b0;
  localparam logic SIDE_INPUT  = 1'b1;

  // Result beat layout, lowest bit first.
  localparam int OFS_COMM   = 0;
  localparam int OFS_SAMPLE = 1;
  localparam int OFS_SEND   = 2;
  localparam int OFS_RECV   = 50;
  localparam int OFS_BUF    = 98;
  localparam int OFS_PAD    = 114;

endpackage

>>> sv/srs_div.sv
// Bit-serial restoring divider shared by the schedule sequencer.
// One quotient bit per cycle; depends on srs_pkg.
module srs_div
  import srs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [IV_BITS-1:0]   divisor,
  output logic                 done,
  output logic [TIME_BITS-1:0] quot,
  output logic [IV_BITS-1:0]   rem
);

  localparam int CW = $clog2(TIME_BITS + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [IV_BITS:0] trial;
  logic [IV_BITS:0] trial_diff;
  logic             fits;

  assign trial      = {rem, quot[TIME_BITS-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign fits       = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(TIME_BITS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[TIME_BITS-2:0], fits};
      rem  <= fits ? trial_diff[IV_BITS-1:0] : trial[IV_BITS-1:0];
    end
  end

endmodule

>>> sv/send_receive_schedule_sync_top.sv
// Top level of the send/receive schedule keeper: configuration registers,
// schedule sequencer with shared offset, subtract and saturating add paths.
// Depends on srs_pkg and srs_div.
//
// One item is worked at a time. A tick item whose local time has not passed
// the active side's next time goes from S_TCMP straight to S_FIN and shows
// its result once the output register is free. A tick that runs the schedule
// advance does up to one division per leg before padding, and an initialize
// item one more for the buffered tick count; the bit-serial divider, one
// quotient bit per cycle, does these divisions. A result sits in an output
// register, so the next item is taken while it waits, from the cycle the
// result appears on. Configuration writes are always taken.
module send_receive_schedule_sync_top
  import srs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // local_time
  input  logic                     s_axis_tuser,  // func
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // communicate, sample_now, next_send, next_receive, buffered_ticks, zero fill
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int W        = (TIME_BITS > FT_BITS) ? TIME_BITS : FT_BITS;
  localparam int SW       = TIME_BITS + 2;
  localparam int AW       = ((TIME_BITS > 40) ? TIME_BITS : 40) + 1;
  localparam int CNT_BITS = (TIME_BITS < 64) ? TIME_BITS + 1 : 64;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_TCMP = 5'd1;
  localparam logic [4:0] S_L1   = 5'd2;
  localparam logic [4:0] S_C1   = 5'd3;
  localparam logic [4:0] S_D1   = 5'd4;
  localparam logic [4:0] S_R1A  = 5'd5;
  localparam logic [4:0] S_R1B  = 5'd6;
  localparam logic [4:0] S_L2   = 5'd7;
  localparam logic [4:0] S_C2   = 5'd8;
  localparam logic [4:0] S_D2   = 5'd9;
  localparam logic [4:0] S_R2A  = 5'd10;
  localparam logic [4:0] S_R2B  = 5'd11;
  localparam logic [4:0] S_PADM = 5'd12;
  localparam logic [4:0] S_PADA = 5'd13;
  localparam logic [4:0] S_IB   = 5'd14;
  localparam logic [4:0] S_IBW  = 5'd15;
  localparam logic [4:0] S_FIN  = 5'd16;

  logic [IV_BITS-1:0]         si_reg;
  logic [IV_BITS-1:0]         ri_reg;
  logic signed [LAT_BITS-1:0] lat_reg;
  logic [MB_BITS-1:0]         mb_reg;
  logic                       side_reg;

  logic [4:0]                 state;
  logic [TIME_BITS-1:0]       send_time;
  logic [TIME_BITS-1:0]       recv_time;
  logic [TIME_BITS-1:0]       lim;
  logic                       below;
  logic [TIME_BITS-1:0]       tmp;
  logic [CNT_BITS-1:0]        count;
  logic [39:0]                prod;
  logic [FT_BITS-1:0]         lt;
  logic                       func;
  logic [BUF_BITS-1:0]        buf_cnt;

  logic [IV_BITS-1:0]   si;
  logic [IV_BITS-1:0]   ri;
  logic [IV_BITS-1:0]   lat_u;
  logic                 lat_pos;
  logic [TIME_BITS-1:0] active;
  logic [W-1:0]         active_w;
  logic [W-1:0]         lt_w;
  logic [W-1:0]         send_w;
  logic [W-1:0]         recv_w;

  logic [TIME_BITS-1:0]    off_base;
  logic signed [33:0]      lat34;
  logic signed [33:0]      ri34;
  logic signed [33:0]      off_delta;
  logic signed [SW-1:0]    off_sum;
  logic                    off_below;
  logic [TIME_BITS-1:0]    off_val;

  logic [TIME_BITS-1:0] sub_b;
  logic [TIME_BITS:0]   sub_diff;
  logic                 sub_neg;

  logic [TIME_BITS-1:0] sat_a;
  logic [39:0]          sat_b;
  logic [AW-1:0]        sat_sum;
  logic [TIME_BITS-1:0] sat_res;

  logic                 div_start;
  logic [TIME_BITS-1:0] div_dividend;
  logic [IV_BITS-1:0]   div_divisor;
  logic                 div_done;
  logic [TIME_BITS-1:0] div_quot;
  logic [IV_BITS-1:0]   div_rem;

  logic [MB_BITS-1:0]   pad_n;
  logic                 ib_inc;
  logic [BUF_BITS:0]    ib_sum;
  logic signed [50:0]   samp_sum;
  logic                 samp_pos;
  logic                 out_load;
  logic                 comm_bit;
  logic                 samp_bit;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  // An interval of zero behaves as one.
  assign si      = (si_reg == '0) ? IV_BITS'(1) : si_reg;
  assign ri      = (ri_reg == '0) ? IV_BITS'(1) : ri_reg;
  assign lat_u   = lat_reg;
  assign lat_pos = !lat_reg[LAT_BITS-1] && (lat_reg != '0);

  assign active   = (side_reg == SIDE_INPUT) ? recv_time : send_time;
  assign active_w = W'(active);
  assign lt_w     = W'(lt);
  assign send_w   = W'(send_time);
  assign recv_w   = W'(recv_time);

  // Clamped offset: first leg uses latency - ri, second leg ri - latency.
  assign lat34     = 34'(lat_reg);
  assign ri34      = $signed({2'b00, ri});
  assign off_base  = (state == S_L1) ? send_time : recv_time;
  assign off_delta = (state == S_L1) ? (lat34 - ri34) : (ri34 - lat34);
  assign off_sum   = $signed({2'b00, off_base}) + SW'(off_delta);
  assign off_below = off_sum[SW-1];
  assign off_val   = (!off_below && off_sum[TIME_BITS]) ? TMAX : off_sum[TIME_BITS-1:0];

  always_comb begin
    case (state)
      S_C1:        sub_b = recv_time;
      S_C2:        sub_b = send_time;
      default:     sub_b = TIME_BITS'(div_rem);
    endcase
  end
  assign sub_diff = {1'b0, lim} - {1'b0, sub_b};
  assign sub_neg  = sub_diff[TIME_BITS];

  always_comb begin
    case (state)
      S_R1B:   sat_b = 40'(ri);
      S_R2B:   sat_b = 40'(si);
      default: sat_b = prod;
    endcase
  end
  assign sat_a   = (state == S_PADA) ? send_time : tmp;
  assign sat_sum = AW'(sat_a) + AW'(sat_b);
  assign sat_res = (sat_sum > AW'(TMAX)) ? TMAX : sat_sum[TIME_BITS-1:0];

  assign div_start = ((state == S_C1 || state == S_C2) && !below && !sub_neg) ||
                     (state == S_IB && lat_pos);
  assign div_dividend = (state == S_IB) ? TIME_BITS'(lat_u - IV_BITS'(1))
                                        : sub_diff[TIME_BITS-1:0];
  // The divider reads its divisor on every step, so it is held for the whole run.
  assign div_divisor  = (state == S_C2 || state == S_D2) ? si : ri;

  srs_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign pad_n  = mb_reg - count[MB_BITS-1:0];
  assign ib_inc = (si < ri) ? (lat_u >= si) : 1'b1;
  assign ib_sum = (BUF_BITS+1)'(div_quot[BUF_BITS-1:0]) + (BUF_BITS+1)'(ib_inc);

  assign samp_sum = $signed({3'b000, lt}) + 51'(lat_reg) + $signed({19'b0, ri});
  assign samp_pos = !samp_sum[50] && (samp_sum != '0);

  assign out_load = (state == S_FIN) && (!m_axis_tvalid || m_axis_tready);
  assign comm_bit = (func == FUNC_TICK) && (lt_w == active_w);
  assign samp_bit = (func == FUNC_TICK) && (side_reg == SIDE_OUTPUT) && samp_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      si_reg   <= IV_BITS'(1);
      ri_reg   <= IV_BITS'(1);
      lat_reg  <= '0;
      mb_reg   <= '0;
      side_reg <= SIDE_OUTPUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEND_IV: si_reg   <= cfg_data;
        REG_RECV_IV: ri_reg   <= cfg_data;
        REG_LATENCY: lat_reg  <= $signed(cfg_data);
        REG_MAX_BUF: mb_reg   <= cfg_data[MB_BITS-1:0];
        REG_SIDE:    side_reg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      send_time <= '0;
      recv_time <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == FUNC_INIT) begin
              send_time <= '0;
              recv_time <= '0;
              state     <= S_L1;
            end else begin
              state <= S_TCMP;
            end
          end
        end
        S_TCMP:  state <= (lt_w > active_w) ? S_L1 : S_FIN;
        S_L1:    state <= S_C1;
        S_C1:    state <= div_start ? S_D1 : S_L2;
        S_D1:    if (div_done) state <= S_R1A;
        S_R1A:   state <= S_R1B;
        S_R1B: begin
          recv_time <= sat_res;
          state     <= S_L2;
        end
        S_L2:    state <= S_C2;
        S_C2:    state <= div_start ? S_D2 : S_PADM;
        S_D2:    if (div_done) state <= S_R2A;
        S_R2A:   state <= S_R2B;
        S_R2B: begin
          send_time <= sat_res;
          state     <= S_PADM;
        end
        S_PADM: begin
          if (count < CNT_BITS'(mb_reg)) begin
            state <= S_PADA;
          end else begin
            state <= (func == FUNC_INIT) ? S_IB : S_FIN;
          end
        end
        S_PADA: begin
          send_time <= sat_res;
          state     <= (func == FUNC_INIT) ? S_IB : S_FIN;
        end
        S_IB:    state <= lat_pos ? S_IBW : S_FIN;
        S_IBW:   if (div_done) state <= S_FIN;
        S_FIN:   if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      lt    <= s_axis_tdata;
      func  <= s_axis_tuser;
      count <= '0;
    end
    if (state == S_L1 || state == S_L2) begin
      lim   <= off_val;
      below <= off_below;
    end
    if (state == S_R1A || state == S_R2A) begin
      tmp <= sub_diff[TIME_BITS-1:0];
    end
    if (state == S_D2 && div_done) begin
      count <= CNT_BITS'({1'b0, div_quot} + {{TIME_BITS{1'b0}}, 1'b1});
    end
    if (state == S_PADM) begin
      prod <= {32'd0, pad_n} * {8'd0, si};
    end
    if (state == S_IB) begin
      buf_cnt <= '0;
    end
    if (state == S_IBW && div_done) begin
      buf_cnt <= ((|div_quot[TIME_BITS-1:BUF_BITS]) || ib_sum[BUF_BITS]) ?
                 {BUF_BITS{1'b1}} : ib_sum[BUF_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata[OFS_COMM]               <= comm_bit;
      m_axis_tdata[OFS_SAMPLE]             <= samp_bit;
      m_axis_tdata[OFS_SEND +: FT_BITS]    <= send_w[FT_BITS-1:0];
      m_axis_tdata[OFS_RECV +: FT_BITS]    <= recv_w[FT_BITS-1:0];
      m_axis_tdata[OFS_BUF +: BUF_BITS]    <= (func == FUNC_INIT) ? buf_cnt : '0;
      m_axis_tdata[OUT_DATA_BITS-1:OFS_PAD] <= '0;
    end
  end

endmodule

>>> sv/srs_checker.sv
// Port-level checks for the schedule keeper, bound to the top level.
// Depends on srs_pkg and send_receive_schedule_sync_top.
module srs_checker
  import srs_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The block works one item at a time: an accepted beat closes the input.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before the item finished");

  // A new result appears as the sequencer returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result shown while the sequencer is still busy");

  // A nonzero buffered count comes only from an initialize item, which
  // never reports communicate or sample.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[OFS_BUF +: BUF_BITS] != '0) |->
      !m_axis_tdata[OFS_COMM] && !m_axis_tdata[OFS_SAMPLE])
    else $error("buffered count on a tick result");

endmodule

bind send_receive_schedule_sync_top srs_checker u_srs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/send_receive_schedule_sync_top_tb.sv
// Self-checking testbench for send_receive_schedule_sync_top.
// Drives tick and initialize beats through a table of directed cases and random phases, and
// checks each beat against the predictor or a known row. Depends on srs_pkg and the RTL.
module send_receive_schedule_sync_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srs_pkg::*;

  typedef logic [63:0] tval_t;

  // Result beat, lowest field in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] backlog;
    logic [47:0] next_receive;
    logic [47:0] next_send;
    logic        sample_now;
    logic        communicate;
  } sched_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [31:0]              data;
    logic                     fn;
    logic [47:0]              lt;
    sched_result_t            known;
  } stim_row_t;

  localparam tval_t TIME_MAX = (64'd1 << TIME_BITS_DEF) - 64'd1;
  localparam logic [47:0] TIME_TOP = '1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = '1;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 200;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;   // local_time
  logic                     s_axis_tuser;   // func
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // communicate, sample_now, next_send, next_receive, buffered_ticks, zero fill
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  send_receive_schedule_sync_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor copy of the registers and the schedule.
  logic [31:0]        reg_send_iv = 32'd1;
  logic [31:0]        reg_recv_iv = 32'd1;
  logic signed [31:0] reg_lat     = '0;
  logic [7:0]         reg_maxbuf  = '0;
  logic               reg_side    = SIDE_OUTPUT;
  tval_t              sched_send  = '0;
  tval_t              sched_recv  = '0;

  sched_result_t pending_sched[$];
  int            mismatches = 0;
  int            results_seen = 0;
  bit            calm = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic tval_t iv_eff(logic [31:0] v);
    return (v == 32'd0) ? tval_t'(1) : tval_t'(v);
  endfunction

  function automatic tval_t clamp_add(tval_t a, tval_t b);
    if (a > TIME_MAX || b > TIME_MAX - a) return TIME_MAX;
    return a + b;
  endfunction

  function automatic tval_t shift_time(tval_t v, longint d, output bit under);
    under = 1'b0;
    if (d >= 0) return clamp_add(v, tval_t'(d));
    if (v < tval_t'(-d)) begin
      under = 1'b1;
      return '0;
    end
    return v - tval_t'(-d);
  endfunction

  // Receive time moves up as far as the latency allows, the send time
  // follows it, and then gets padded by the buffering depth not yet used.
  function automatic void run_advance();
    tval_t si, ri, lim, q, steps;
    bit    under;
    si    = iv_eff(reg_send_iv);
    ri    = iv_eff(reg_recv_iv);
    steps = '0;
    lim = shift_time(sched_send, longint'(reg_lat) - longint'(ri), under);
    if (!under && sched_recv <= lim) begin
      q = (lim - sched_recv) / ri;
      sched_recv = clamp_add(sched_recv + q * ri, ri);
    end
    lim = shift_time(sched_recv, longint'(ri) - longint'(reg_lat), under);
    if (!under && sched_send <= lim) begin
      q = (lim - sched_send) / si;
      steps = q + 64'd1;
      sched_send = clamp_add(sched_send + q * si, si);
    end
    if (steps < tval_t'(reg_maxbuf))
      sched_send = clamp_add(sched_send, (tval_t'(reg_maxbuf) - steps) * si);
  endfunction

  function automatic logic [15:0] start_backlog();
    tval_t si, ri, t, lat;
    si = iv_eff(reg_send_iv);
    ri = iv_eff(reg_recv_iv);
    if (reg_lat <= 0) return '0;
    lat = tval_t'(longint'(reg_lat));
    t = (lat - 64'd1) / ri;
    if (si < ri) begin
      if (lat >= si) t = t + 64'd1;
    end else begin
      t = t + 64'd1;
    end
    return (t > 64'd65535) ? 16'hFFFF : t[15:0];
  endfunction

  function automatic sched_result_t schedule_step(logic fn, logic [47:0] lt);
    sched_result_t r;
    tval_t         now, active;
    longint        s;
    r   = '0;
    now = {16'd0, lt};
    if (fn == FUNC_INIT) begin
      sched_send = '0;
      sched_recv = '0;
      run_advance();
      r.backlog = start_backlog();
    end else begin
      active = (reg_side == SIDE_INPUT) ? sched_recv : sched_send;
      if (now > active) begin
        run_advance();
        active = (reg_side == SIDE_INPUT) ? sched_recv : sched_send;
      end
      r.communicate = (now == active);
      if (reg_side == SIDE_OUTPUT) begin
        s = longint'(now) + longint'(reg_lat) + longint'(iv_eff(reg_recv_iv));
        r.sample_now = (s > 0);
      end
    end
    r.next_send    = sched_send[47:0];
    r.next_receive = sched_recv[47:0];
    return r;
  endfunction

  function automatic sched_result_t res(logic comm, logic samp, logic [47:0] snd,
                                        logic [47:0] rcv, logic [15:0] bk);
    sched_result_t r;
    r = '0;
    r.communicate  = comm;
    r.sample_now   = samp;
    r.next_send    = snd;
    r.next_receive = rcv;
    r.backlog      = bk;
    return r;
  endfunction

  function automatic stim_row_t wr_row(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = val;
    return row;
  endfunction

  function automatic stim_row_t item_row(logic fn, logic [47:0] lt);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.fn   = fn;
    row.lt   = lt;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic fn, logic [47:0] lt, sched_result_t r);
    stim_row_t row;
    row       = item_row(fn, lt);
    row.kind  = ROW_KNOWN;
    row.known = r;
    return row;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [31:0] pick_interval();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [47:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Leaves tvalid high after the accepting edge so that back-to-back beats
  // need only one assignment per edge.
  task automatic push_item(input logic fn, input logic [47:0] lt, input bit use_known,
                           input sched_result_t known);
    int            gap;
    sched_result_t want;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= lt;
    do @(posedge clk); while (!s_axis_tready);
    want = schedule_step(fn, lt);
    if (use_known) want = known;
    pending_sched.push_back(want);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_sched.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SEND_IV: reg_send_iv = val;
      REG_RECV_IV: reg_recv_iv = val;
      REG_LATENCY: reg_lat     = val;
      REG_MAX_BUF: reg_maxbuf  = val[7:0];
      REG_SIDE:    reg_side    = val[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    stim_row_t     plan[$];
    stim_row_t     row;
    bit            writing;
    tval_t         active, clock_now;
    logic [47:0]   lt;
    logic          fn;
    logic [31:0]   lat_val;
    int            pick;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_INIT;

    // Reset values: no receive advance since the limit falls below zero.
    plan.push_back(known_row(FUNC_INIT, 48'd0, res(1'b0, 1'b0, 48'd2, 48'd0, 16'd0)));
    plan.push_back(known_row(FUNC_TICK, 48'd0, res(1'b0, 1'b1, 48'd2, 48'd0, 16'd0)));
    plan.push_back(known_row(FUNC_TICK, 48'd2, res(1'b1, 1'b1, 48'd2, 48'd0, 16'd0)));
    plan.push_back(known_row(FUNC_TICK, TIME_TOP, res(1'b0, 1'b1, 48'd4, 48'd2, 16'd0)));
    plan.push_back(wr_row(REG_SIDE, {31'd0, SIDE_INPUT}));
    plan.push_back(known_row(FUNC_TICK, 48'd2, res(1'b1, 1'b0, 48'd4, 48'd2, 16'd0)));
    plan.push_back(item_row(FUNC_TICK, 48'd3));
    // Zero send interval, widest receive interval, largest latency and depth.
    plan.push_back(wr_row(REG_SEND_IV, 32'd0));
    plan.push_back(wr_row(REG_RECV_IV, 32'hFFFF_FFFF));
    plan.push_back(wr_row(REG_LATENCY, 32'h7FFF_FFFF));
    plan.push_back(wr_row(REG_MAX_BUF, 32'd255));
    plan.push_back(wr_row(REG_SIDE, {31'd0, SIDE_OUTPUT}));
    plan.push_back(wr_row(REG_SPARE, 32'hFFFF_FFFF));
    plan.push_back(item_row(FUNC_INIT, TIME_TOP));
    plan.push_back(item_row(FUNC_TICK, 48'd0));
    plan.push_back(item_row(FUNC_TICK, TIME_TOP));
    plan.push_back(item_row(FUNC_TICK, TIME_TOP));
    // Most negative latency with a zero receive interval.
    plan.push_back(wr_row(REG_SEND_IV, 32'hFFFF_FFFF));
    plan.push_back(wr_row(REG_RECV_IV, 32'd0));
    plan.push_back(wr_row(REG_LATENCY, 32'h8000_0000));
    plan.push_back(item_row(FUNC_INIT, 48'd0));
    plan.push_back(item_row(FUNC_TICK, 48'd0));
    plan.push_back(item_row(FUNC_TICK, TIME_TOP));
    // The buffered tick count saturates here.
    plan.push_back(wr_row(REG_LATENCY, 32'h7FFF_FFFF));
    plan.push_back(wr_row(REG_RECV_IV, 32'd1));
    plan.push_back(wr_row(REG_SEND_IV, 32'd1));
    plan.push_back(wr_row(REG_MAX_BUF, 32'd0));
    plan.push_back(item_row(FUNC_INIT, 48'd0));
    // Negative latency keeps the sample flag low until local time plus latency and receive interval is positive.
    plan.push_back(wr_row(REG_LATENCY, 32'hFFFF_FFFB));
    plan.push_back(wr_row(REG_SEND_IV, 32'd3));
    plan.push_back(item_row(FUNC_INIT, 48'd0));
    plan.push_back(item_row(FUNC_TICK, 48'd0));
    plan.push_back(item_row(FUNC_TICK, 48'd4));
    plan.push_back(item_row(FUNC_TICK, 48'd5));
    plan.push_back(wr_row(REG_SIDE, {31'd0, SIDE_INPUT}));
    plan.push_back(item_row(FUNC_TICK, 48'd5));
    plan.push_back(wr_row(REG_SIDE, {31'd0, SIDE_OUTPUT}));
    plan.push_back(wr_row(REG_MAX_BUF, 32'd3));
    plan.push_back(wr_row(REG_LATENCY, 32'd0));
    plan.push_back(wr_row(REG_SEND_IV, 32'd2));
    plan.push_back(wr_row(REG_RECV_IV, 32'd3));
    plan.push_back(item_row(FUNC_INIT, 48'd0));
    plan.push_back(item_row(FUNC_TICK, 48'd1));
    plan.push_back(item_row(FUNC_TICK, 48'd2));
    plan.push_back(item_row(FUNC_TICK, 48'd6));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    writing = 1'b0;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        if (!writing) wait_drained();
        writing = 1'b1;
        write_reg(row.idx, row.data);
      end else begin
        if (writing) end_writes();
        writing = 1'b0;
        push_item(row.fn, row.lt, row.kind == ROW_KNOWN, row.known);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 2 || ph == 9);
      wait_drained();
      if (ph == 6) begin
        // Widest intervals and deepest buffering push both times into saturation.
        write_reg(REG_SEND_IV, '1);
        write_reg(REG_RECV_IV, '1);
        write_reg(REG_LATENCY, 32'h7FFF_FFFF);
        write_reg(REG_MAX_BUF, 32'd255);
        write_reg(REG_SIDE, $urandom_range(0, 1));
        end_writes();
        push_item(FUNC_INIT, rand_time(), 1'b0, '0);
        for (int k = 0; k < 300; k++) begin
          lt = ($urandom_range(0, 7) == 0) ? TIME_TOP - 48'($urandom_range(0, 2))
                                           : TIME_TOP;
          push_item(FUNC_TICK, lt, 1'b0, '0);
        end
      end else begin
        write_reg(REG_SEND_IV, pick_interval());
        write_reg(REG_RECV_IV, pick_interval());
        case ($urandom_range(0, 7))
          0:       lat_val = 32'h7FFF_FFFF;
          1:       lat_val = 32'h8000_0000;
          2:       lat_val = $urandom;
          default: lat_val = $urandom_range(0, 60) - 32'd30;
        endcase
        write_reg(REG_LATENCY, lat_val);
        case ($urandom_range(0, 5))
          0:       write_reg(REG_MAX_BUF, 32'd255);
          1:       write_reg(REG_MAX_BUF, $urandom_range(0, 255));
          default: write_reg(REG_MAX_BUF, $urandom_range(0, 4));
        endcase
        write_reg(REG_SIDE, $urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
          write_reg(CFG_IDX_BITS'($urandom_range(int'(REG_SIDE) + 1, int'(REG_SPARE))),
                    $urandom);
        end_writes();
        push_item(FUNC_INIT, rand_time(), 1'b0, '0);
        clock_now = '0;
        for (int k = 0; k < 75; k++) begin
          if (ph == 4 && k == 40) wait_drained();
          active = (reg_side == SIDE_INPUT) ? sched_recv : sched_send;
          fn   = FUNC_TICK;
          pick = $urandom_range(0, 99);
          if (pick < 4) begin
            fn = FUNC_INIT;
            lt = rand_time();
          end else if (pick < 10) begin
            lt = rand_time();
          end else if (pick < 13) begin
            lt = TIME_TOP - 48'($urandom_range(0, 3));
          end else if (pick < 38) begin
            lt = 48'(active + tval_t'($urandom_range(0, 2)) - 64'd1);
          end else begin
            // A local clock that walks forward and is pulled up when the
            // schedule has run far ahead of it.
            clock_now = clock_now + tval_t'($urandom_range(0, 3));
            if (clock_now + 64'd20 < active)
              clock_now = active - tval_t'($urandom_range(0, 3));
            lt = clock_now[47:0];
          end
          push_item(fn, lt, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** send_receive_schedule_sync_top: PASSED **");
    else
      $display("** send_receive_schedule_sync_top: FAILED **");
    $finish;
  end

  initial begin : result_sink
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Values read right after the edge are the ones the block saw at it.
  always @(posedge clk) begin : result_check
    sched_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (pending_sched.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d arrived with nothing expected: %h", results_seen, got);
      end else begin
        want = pending_sched.pop_front();
        if (got.communicate !== want.communicate || got.sample_now !== want.sample_now ||
            got.next_send !== want.next_send || got.next_receive !== want.next_receive ||
            got.backlog !== want.backlog || got.pad !== want.pad) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result beat %0d mismatch (expected/actual): communicate %b/%b ",
                      "sample %b/%b send %h/%h receive %h/%h buffered %h/%h fill %h/%h"},
                     results_seen, want.communicate, got.communicate, want.sample_now,
                     got.sample_now, want.next_send, got.next_send, want.next_receive,
                     got.next_receive, want.backlog, got.backlog, want.pad, got.pad);
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("no beat moved for %0d cycles", STALL_LIMIT);
    $display("** send_receive_schedule_sync_top: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
sv/srs_pkg.sv
sv/srs_div.sv
sv/send_receive_schedule_sync_top.sv
sv/srs_checker.sv
tb/send_receive_schedule_sync_top_tb.sv
